// File: sv/tlvox_pkg.sv
// tlvox_pkg: shared types and constants for the tlv option extractor
// no dependencies; used by tlv_option_extractor
package tlvox_pkg;

    localparam int OPTIONS_START_DEF = 240;
    localparam int MAX_BYTES_DEF     = 1024;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int INDEX_W  = 17;
    localparam int PAD_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;

    localparam logic [BYTE_W-1:0] END_MARK = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDING_MODE  = 2'd2;

    // padding modes
    localparam logic [PAD_W-1:0] PAD_ODD  = 2'd1;
    localparam logic [PAD_W-1:0] PAD_EVEN = 2'd2;

    typedef enum logic [2:0] {
        PH_BEFORE = 3'd0,
        PH_ID     = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_SKIP   = 3'd4,
        PH_COPY   = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_MORE      = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_SIZE_ERR  = 3'd4
    } t_status;

endpackage

// File: sv/tlv_option_extractor.sv
// tlv_option_extractor: walks tlv options in a packet byte stream and copies
// the data of the wanted option; depends on tlvox_pkg
//
// One packet byte is taken per cycle while the output register is free or
// draining, with no gaps needed between beats. Each beat is decoded against
// the parse state and its result, if any, is registered in the output
// register when the beat is accepted. The output register sits between the
// two sides: a new byte is taken while the last result waits, as long as
// that result is being drained in the same cycle. tlast on the input marks
// the last byte of a packet; tlast on the output marks the final result of a
// packet (complete, not found, malformed or size mismatch).
module tlv_option_extractor #(
    parameter int OPTIONS_START = tlvox_pkg::OPTIONS_START_DEF,
    parameter int MAX_BYTES     = tlvox_pkg::MAX_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [tlvox_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tlvox_pkg::CFG_W-1:0]   i_cfg_data,
    // input beats
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // packet_byte
    input  logic                          s_axis_tlast,  // packet_end
    // result beats
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // out_byte, out_index, zero fill
    output logic [3:0]                    m_axis_tuser,  // has_byte, status
    output logic                          m_axis_tlast   // final_res
);

    localparam int POS_MAX = (MAX_BYTES > OPTIONS_START) ? MAX_BYTES : OPTIONS_START;
    localparam int POS_W   = $clog2(POS_MAX + 1);
    localparam int SUM_W   = ((POS_W > tlvox_pkg::LEN_W) ? POS_W : tlvox_pkg::LEN_W) + 2;
    localparam int BW      = tlvox_pkg::BYTE_W;
    localparam int LW      = tlvox_pkg::LEN_W;
    localparam int IW      = tlvox_pkg::INDEX_W;

    // configuration
    logic [BW-1:0]               r_wanted_id;
    logic [LW-1:0]               r_expected_size;
    logic [tlvox_pkg::PAD_W-1:0] r_padding_mode;

    // parse state
    logic [POS_W-1:0]        r_pos, n_pos;
    tlvox_pkg::t_phase       r_phase, n_phase, phase_eff;
    logic [BW-1:0]           r_len_lo, n_len_lo;
    logic [LW-1:0]           r_bytes_left, n_bytes_left;
    logic [LW-1:0]           r_copy_count, n_copy_count;
    logic                    r_matched, n_matched;

    // output register
    logic                    r_out_valid;
    logic [BW-1:0]           r_out_byte, n_out_byte;
    logic [IW-1:0]           r_out_index, n_out_index;
    logic                    r_has_byte, n_has_byte;
    tlvox_pkg::t_status      r_status, n_status;
    logic                    r_final, n_final;
    logic                    n_emit;

    logic                    accept;
    logic                    active;
    logic                    over_bound;
    logic [LW-1:0]           len;
    logic [SUM_W-1:0]        skip_sum;
    logic                    skip_bad;
    logic [LW-1:0]           bytes_dec;
    logic [BW-1:0]           in_byte;

    assign in_byte       = s_axis_tdata;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign phase_eff = (r_phase == tlvox_pkg::PH_BEFORE && r_pos >= POS_W'(OPTIONS_START))
                       ? tlvox_pkg::PH_ID : r_phase;
    assign active     = (phase_eff == tlvox_pkg::PH_ID)     ||
                        (phase_eff == tlvox_pkg::PH_LEN_LO) ||
                        (phase_eff == tlvox_pkg::PH_LEN_HI) ||
                        (phase_eff == tlvox_pkg::PH_SKIP)   ||
                        (phase_eff == tlvox_pkg::PH_COPY);
    assign over_bound = active && (r_pos >= POS_W'(MAX_BYTES));
    assign len        = {in_byte, r_len_lo};
    assign skip_sum   = SUM_W'(r_pos) + SUM_W'(len) + SUM_W'(3);
    assign skip_bad   = skip_sum >= SUM_W'(MAX_BYTES);
    assign bytes_dec  = r_bytes_left - LW'(1);

    // next state
    always_comb begin
        n_phase      = phase_eff;
        n_len_lo     = r_len_lo;
        n_bytes_left = r_bytes_left;
        n_copy_count = r_copy_count;
        n_matched    = r_matched;
        n_pos        = (r_pos < POS_W'(POS_MAX)) ? r_pos + POS_W'(1) : r_pos;
        if (over_bound) begin
            n_phase = tlvox_pkg::PH_DONE;
        end else begin
            unique case (phase_eff)
                tlvox_pkg::PH_ID: begin
                    if (in_byte == r_wanted_id) begin
                        n_matched = 1'b1;
                        n_phase   = tlvox_pkg::PH_LEN_LO;
                    end else if (in_byte == tlvox_pkg::END_MARK) begin
                        n_phase = tlvox_pkg::PH_DONE;
                    end else begin
                        n_matched = 1'b0;
                        n_phase   = tlvox_pkg::PH_LEN_LO;
                    end
                end
                tlvox_pkg::PH_LEN_LO: begin
                    n_len_lo = in_byte;
                    n_phase  = tlvox_pkg::PH_LEN_HI;
                end
                tlvox_pkg::PH_LEN_HI: begin
                    if (r_matched) begin
                        if ((r_expected_size != '0 && len != r_expected_size) || len == '0) begin
                            n_phase = tlvox_pkg::PH_DONE;
                        end else begin
                            n_bytes_left = len;
                            n_copy_count = '0;
                            n_phase      = tlvox_pkg::PH_COPY;
                        end
                    end else if (skip_bad) begin
                        n_phase = tlvox_pkg::PH_DONE;
                    end else if (len == '0) begin
                        n_phase = tlvox_pkg::PH_ID;
                    end else begin
                        n_bytes_left = len;
                        n_phase      = tlvox_pkg::PH_SKIP;
                    end
                end
                tlvox_pkg::PH_SKIP: begin
                    n_bytes_left = bytes_dec;
                    if (bytes_dec == '0) begin
                        n_phase = tlvox_pkg::PH_ID;
                    end
                end
                tlvox_pkg::PH_COPY: begin
                    n_copy_count = r_copy_count + LW'(1);
                    n_bytes_left = bytes_dec;
                    if (bytes_dec == '0) begin
                        n_phase = tlvox_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // result of the beat
    always_comb begin
        n_emit      = 1'b0;
        n_out_byte  = '0;
        n_out_index = '0;
        n_has_byte  = 1'b0;
        n_status    = tlvox_pkg::ST_MORE;
        n_final     = 1'b0;
        if (over_bound) begin
            n_emit   = 1'b1;
            n_status = tlvox_pkg::ST_MALFORMED;
            n_final  = 1'b1;
        end else begin
            unique case (phase_eff)
                tlvox_pkg::PH_ID: begin
                    if (in_byte != r_wanted_id && in_byte == tlvox_pkg::END_MARK) begin
                        n_emit   = 1'b1;
                        n_status = tlvox_pkg::ST_NOT_FOUND;
                        n_final  = 1'b1;
                    end
                end
                tlvox_pkg::PH_LEN_HI: begin
                    if (r_matched) begin
                        if (r_expected_size != '0 && len != r_expected_size) begin
                            n_emit   = 1'b1;
                            n_status = tlvox_pkg::ST_SIZE_ERR;
                            n_final  = 1'b1;
                        end else if (len == '0) begin
                            n_emit   = 1'b1;
                            n_status = tlvox_pkg::ST_COMPLETE;
                            n_final  = 1'b1;
                        end
                    end else if (skip_bad) begin
                        n_emit   = 1'b1;
                        n_status = tlvox_pkg::ST_MALFORMED;
                        n_final  = 1'b1;
                    end
                end
                tlvox_pkg::PH_COPY: begin
                    n_emit     = 1'b1;
                    n_has_byte = 1'b1;
                    n_out_byte = in_byte;
                    case (r_padding_mode)
                        tlvox_pkg::PAD_ODD:  n_out_index = {r_copy_count, 1'b0};
                        tlvox_pkg::PAD_EVEN: n_out_index = {r_copy_count, 1'b1};
                        default:             n_out_index = IW'(r_copy_count);
                    endcase
                    if (bytes_dec == '0) begin
                        n_status = tlvox_pkg::ST_COMPLETE;
                        n_final  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        // packet ended before a final result
        if (s_axis_tlast && n_phase != tlvox_pkg::PH_DONE) begin
            n_emit   = 1'b1;
            n_status = tlvox_pkg::ST_MALFORMED;
            n_final  = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_id     <= '0;
            r_expected_size <= '0;
            r_padding_mode  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tlvox_pkg::CFG_WANTED_ID:     r_wanted_id     <= i_cfg_data[BW-1:0];
                tlvox_pkg::CFG_EXPECTED_SIZE: r_expected_size <= i_cfg_data[LW-1:0];
                tlvox_pkg::CFG_PADDING_MODE:  r_padding_mode  <= i_cfg_data[tlvox_pkg::PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // parse state, restarts after the last byte of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_phase      <= tlvox_pkg::PH_BEFORE;
            r_len_lo     <= '0;
            r_bytes_left <= '0;
            r_copy_count <= '0;
            r_matched    <= 1'b0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                r_pos        <= '0;
                r_phase      <= tlvox_pkg::PH_BEFORE;
                r_len_lo     <= '0;
                r_bytes_left <= '0;
                r_copy_count <= '0;
                r_matched    <= 1'b0;
            end else begin
                r_pos        <= n_pos;
                r_phase      <= n_phase;
                r_len_lo     <= n_len_lo;
                r_bytes_left <= n_bytes_left;
                r_copy_count <= n_copy_count;
                r_matched    <= n_matched;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out_byte  <= n_out_byte;
            r_out_index <= n_out_index;
            r_has_byte  <= n_has_byte;
            r_status    <= n_status;
            r_final     <= n_final;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_index, r_out_byte};
    assign m_axis_tuser  = {r_status, r_has_byte};
    assign m_axis_tlast  = r_final;

    // checks
    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_has_byte) |->
            (r_status == tlvox_pkg::ST_MORE || r_status == tlvox_pkg::ST_COMPLETE || r_final))
        else $error("data beat with an error status that is not final");

    a_final_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_final == (r_status != tlvox_pkg::ST_MORE)))
        else $error("final flag disagrees with status");

    a_empty_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_has_byte) |-> (r_out_byte == '0 && r_out_index == '0))
        else $error("payload set on a beat without data");

    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tlvox_pkg::PH_COPY || r_phase == tlvox_pkg::PH_SKIP) |-> (r_bytes_left != '0))
        else $error("copy or skip with no bytes left");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for tlv_option_extractor, packets of tlv options under random
// stalls on both stream sides, results checked against a cycle-free parse model
// depends on tlvox_pkg and tlv_option_extractor
module tb;

    localparam int OPTS       = tlvox_pkg::OPTIONS_START_DEF;
    localparam int MAXB       = tlvox_pkg::MAX_BYTES_DEF;
    localparam int SKIP_FILL  = MAXB - OPTS - 6;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int PHASE_ITEMS = 205;

    localparam logic [tlvox_pkg::PAD_W-1:0] PAD_NORMAL = 2'd0;
    localparam logic [tlvox_pkg::PAD_W-1:0] PAD_SPARE  = 2'd3;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [16:0]        out_index;
        logic               has_byte;
        tlvox_pkg::t_status status;
        logic               final_res;
    } t_option_result;

    class t_scoreboard;
        int unsigned        opt_start;
        int unsigned        max_bytes;
        logic [7:0]         wanted_id;
        logic [15:0]        expected_size;
        logic [1:0]         pad_mode;
        int unsigned        pos;
        tlvox_pkg::t_phase  phase;
        logic [7:0]         len_lo;
        logic [15:0]        remaining;
        logic [15:0]        copied;
        bit                 matched;
        t_option_result     due_results[$];
        int unsigned        errors;
        int unsigned        n_beats;
        int unsigned        n_results;
        int unsigned        n_data;
        int unsigned        status_seen[5];

        function new(int unsigned start, int unsigned limit);
            opt_start     = start;
            max_bytes     = limit;
            wanted_id     = '0;
            expected_size = '0;
            pad_mode      = '0;
            errors        = 0;
            n_beats       = 0;
            n_results     = 0;
            n_data        = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            restart();
        endfunction

        function void restart();
            pos       = 0;
            phase     = tlvox_pkg::PH_BEFORE;
            len_lo    = '0;
            remaining = '0;
            copied    = '0;
            matched   = 1'b0;
        endfunction

        function void set_reg(logic [tlvox_pkg::CFG_IDX_W-1:0] idx,
                              logic [tlvox_pkg::CFG_W-1:0] data);
            case (idx)
                tlvox_pkg::CFG_WANTED_ID:     wanted_id = data[7:0];
                tlvox_pkg::CFG_EXPECTED_SIZE: expected_size = data;
                tlvox_pkg::CFG_PADDING_MODE:  pad_mode = data[1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        // one accepted packet byte: advance the parse and queue the result it causes
        function void take_byte(logic [7:0] b, logic last);
            t_option_result r;
            bit             emit;
            int unsigned    len;
            r        = '0;
            r.status = tlvox_pkg::ST_MORE;
            emit     = 1'b0;
            n_beats++;
            if (phase == tlvox_pkg::PH_BEFORE && pos >= opt_start) phase = tlvox_pkg::PH_ID;
            if (phase >= tlvox_pkg::PH_ID && phase <= tlvox_pkg::PH_COPY && pos >= max_bytes)
            begin
                emit = 1'b1; r.status = tlvox_pkg::ST_MALFORMED; r.final_res = 1'b1;
                phase = tlvox_pkg::PH_DONE;
            end else begin
                case (phase)
                    tlvox_pkg::PH_ID: begin
                        if (b == wanted_id) begin
                            matched = 1'b1; phase = tlvox_pkg::PH_LEN_LO;
                        end else if (b == tlvox_pkg::END_MARK) begin
                            emit = 1'b1; r.status = tlvox_pkg::ST_NOT_FOUND;
                            r.final_res = 1'b1;
                            phase = tlvox_pkg::PH_DONE;
                        end else begin
                            matched = 1'b0; phase = tlvox_pkg::PH_LEN_LO;
                        end
                    end
                    tlvox_pkg::PH_LEN_LO: begin
                        len_lo = b;
                        phase  = tlvox_pkg::PH_LEN_HI;
                    end
                    tlvox_pkg::PH_LEN_HI: begin
                        len = {b, len_lo};
                        if (matched) begin
                            if (expected_size != 0 && len != expected_size) begin
                                emit = 1'b1; r.status = tlvox_pkg::ST_SIZE_ERR;
                                r.final_res = 1'b1;
                                phase = tlvox_pkg::PH_DONE;
                            end else if (len == 0) begin
                                emit = 1'b1; r.status = tlvox_pkg::ST_COMPLETE;
                                r.final_res = 1'b1;
                                phase = tlvox_pkg::PH_DONE;
                            end else begin
                                remaining = 16'(len); copied = '0;
                                phase = tlvox_pkg::PH_COPY;
                            end
                        end else begin
                            if (pos + len + 3 >= max_bytes) begin
                                emit = 1'b1; r.status = tlvox_pkg::ST_MALFORMED;
                                r.final_res = 1'b1;
                                phase = tlvox_pkg::PH_DONE;
                            end else if (len == 0) begin
                                phase = tlvox_pkg::PH_ID;
                            end else begin
                                remaining = 16'(len); phase = tlvox_pkg::PH_SKIP;
                            end
                        end
                    end
                    tlvox_pkg::PH_SKIP: begin
                        remaining--;
                        if (remaining == 0) phase = tlvox_pkg::PH_ID;
                    end
                    tlvox_pkg::PH_COPY: begin
                        emit       = 1'b1;
                        r.has_byte = 1'b1;
                        r.out_byte = b;
                        if (pad_mode == tlvox_pkg::PAD_ODD) r.out_index = {copied, 1'b0};
                        else if (pad_mode == tlvox_pkg::PAD_EVEN) r.out_index = {copied, 1'b1};
                        else r.out_index = {1'b0, copied};
                        copied++;
                        remaining--;
                        if (remaining == 0) begin
                            r.status = tlvox_pkg::ST_COMPLETE; r.final_res = 1'b1;
                            phase = tlvox_pkg::PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            if (pos < 4095) pos++;
            if (last) begin
                if (phase != tlvox_pkg::PH_DONE) begin
                    emit = 1'b1; r.status = tlvox_pkg::ST_MALFORMED; r.final_res = 1'b1;
                end
                restart();
            end
            if (emit) due_results.push_back(r);
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            errors++;
            if (errors <= 40)
                $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h",
                         $time, what, got, want);
        endtask

        task check_result(logic [31:0] tdata, logic [3:0] tuser, logic tlast);
            t_option_result e;
            if (due_results.size() == 0) begin
                report("unexpected result beat", tdata, 0);
                return;
            end
            e = due_results.pop_front();
            n_results++;
            if (e.has_byte) n_data++;
            status_seen[e.status]++;
            if (tdata[7:0] !== e.out_byte) report("out_byte", tdata[7:0], e.out_byte);
            if (tdata[24:8] !== e.out_index) report("out_index", tdata[24:8], e.out_index);
            if (tdata[31:25] !== 7'd0) report("tdata fill", tdata[31:25], 0);
            if (tuser[0] !== e.has_byte) report("has_byte", tuser[0], e.has_byte);
            if (tuser[3:1] !== e.status) report("status", tuser[3:1], e.status);
            if (tlast !== e.final_res) report("final_res", tlast, e.final_res);
        endtask
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [tlvox_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [tlvox_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = '0;   // packet_byte
    logic                            s_axis_tlast = 1'b0; // packet_end
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [31:0]                     m_axis_tdata;        // out_byte, out_index, zero fill
    logic [3:0]                      m_axis_tuser;        // has_byte, status
    logic                            m_axis_tlast;        // final_res

    t_scoreboard   sb;
    logic [7:0]    pkt[$];
    int unsigned   src_idle_pct = 0;
    int unsigned   snk_stall_pct = 0;
    int unsigned   n_packets = 0;
    int unsigned   n_settings = 0;

    tlv_option_extractor #(
        .OPTIONS_START(OPTS),
        .MAX_BYTES    (MAXB)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.take_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    task automatic push_byte(logic [7:0] b, logic l);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // pause_at: index of a byte before which the sender waits for all results
    task automatic send_packet(int pause_at);
        for (int i = 0; i < pkt.size(); i++) begin
            if (i == pause_at) drain();
            push_byte(pkt[i], i == pkt.size() - 1);
        end
        n_packets++;
    endtask

    task automatic write_cfg(logic [7:0] id, logic [15:0] size,
                             logic [tlvox_pkg::PAD_W-1:0] pad);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tlvox_pkg::CFG_WANTED_ID;
        i_cfg_data  <= {8'd0, id};
        sb.set_reg(tlvox_pkg::CFG_WANTED_ID, {8'd0, id});
        @(posedge i_clk);
        i_cfg_index <= tlvox_pkg::CFG_EXPECTED_SIZE;
        i_cfg_data  <= size;
        sb.set_reg(tlvox_pkg::CFG_EXPECTED_SIZE, size);
        @(posedge i_clk);
        i_cfg_index <= tlvox_pkg::CFG_PADDING_MODE;
        i_cfg_data  <= {14'd0, pad};
        sb.set_reg(tlvox_pkg::CFG_PADDING_MODE, {14'd0, pad});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic random_config();
        logic [7:0]                  id;
        logic [15:0]                 size;
        logic [tlvox_pkg::PAD_W-1:0] pad;
        case ($urandom_range(0, 3))
            0: id = 8'h00;
            1: id = tlvox_pkg::END_MARK;
            default: id = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: size = 16'hFFFF;
            1: size = 16'($urandom);
            2, 3: size = 16'($urandom_range(1, 24));
            default: size = '0;
        endcase
        pad = tlvox_pkg::PAD_W'($urandom);
        write_cfg(id, size, pad);
    endtask

    task automatic start_packet();
        pkt.delete();
        repeat (OPTS) pkt.push_back(8'($urandom));
    endtask

    task automatic add_option(logic [7:0] id, logic [15:0] len, int n_data);
        pkt.push_back(id);
        pkt.push_back(len[7:0]);
        pkt.push_back(len[15:8]);
        repeat (n_data) pkt.push_back(8'($urandom));
    endtask

    function automatic logic [7:0] other_id();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 254)); while (v == sb.wanted_id);
        return v;
    endfunction

    task automatic build_random_packet();
        int unsigned kind;
        int          n;
        logic [15:0] len;
        start_packet();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 4)) begin
            n = $urandom_range(0, 6);
            add_option(other_id(), 16'(n), n);
        end
        kind = $urandom_range(0, 99);
        if (kind >= 55 && kind < 70 && sb.expected_size == 0) kind = 0;
        if (kind >= 70 && kind < 82 && sb.wanted_id == tlvox_pkg::END_MARK) kind = 0;
        if (kind < 55) begin
            if (sb.expected_size != 0) len = sb.expected_size;
            else if ($urandom_range(0, 9) == 0) len = 16'($urandom);
            else len = 16'($urandom_range(0, 24));
            n = (len > 24) ? 24 : int'(len);
            add_option(sb.wanted_id, len, n);
        end else if (kind < 70) begin
            len = sb.expected_size + 16'($urandom_range(1, 65535));
            add_option(sb.wanted_id, len, 0);
        end else if (kind < 82) begin
            pkt.push_back(tlvox_pkg::END_MARK);
        end else if (kind < 90) begin
            add_option(other_id(), 16'($urandom_range(MAXB, 65535)), 0);
        end else begin
            // header cut short by the end of the packet
            pkt.push_back($urandom_range(0, 1) ? sb.wanted_id : other_id());
            if ($urandom_range(0, 1)) pkt.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int unsigned phase_items;
        int unsigned since_cfg;
        sb = new(OPTS, MAXB);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: skip an option, copy a two byte one, hold off mid copy
        start_packet();
        add_option(8'd7, 16'd1, 1);
        add_option(8'h00, 16'd2, 2);
        send_packet(OPTS + 8);
        // packet ends before the options start
        pkt.delete();
        repeat (3) pkt.push_back(8'($urandom));
        send_packet(-1);
        // wanted id equal to the end marker
        write_cfg(tlvox_pkg::END_MARK, 16'd0, tlvox_pkg::PAD_EVEN);
        start_packet();
        add_option(tlvox_pkg::END_MARK, 16'd1, 0);
        pkt.push_back(tlvox_pkg::END_MARK);
        send_packet(-1);
        write_cfg(tlvox_pkg::END_MARK, 16'd0, PAD_SPARE);
        start_packet();
        add_option(tlvox_pkg::END_MARK, 16'd0, 0);
        send_packet(-1);
        start_packet();
        add_option(tlvox_pkg::END_MARK, 16'd2, 2);
        send_packet(-1);
        // packet ends during a copy, then a size mismatch
        write_cfg(8'h00, 16'hFFFF, tlvox_pkg::PAD_ODD);
        start_packet();
        add_option(8'h00, 16'hFFFF, 2);
        send_packet(-1);
        start_packet();
        add_option(8'h00, 16'd3, 2);
        send_packet(-1);
        // end marker, skip past the bound, copy running past the buffer
        write_cfg(8'h12, 16'd0, PAD_NORMAL);
        start_packet();
        pkt.push_back(tlvox_pkg::END_MARK);
        pkt.push_back(8'($urandom));
        send_packet(-1);
        start_packet();
        add_option(8'd1, 16'hFFFF, 1);
        send_packet(-1);
        start_packet();
        add_option(8'd1, 16'(SKIP_FILL), SKIP_FILL);
        add_option(8'h12, 16'd5, 2);
        send_packet(-1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 59; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 59; end
                default: begin src_idle_pct = 10; snk_stall_pct = 10; end
            endcase
            phase_items = 0;
            since_cfg = 6;
            while (phase_items < PHASE_ITEMS) begin
                if (since_cfg >= 6) begin
                    random_config();
                    since_cfg = 0;
                end
                build_random_packet();
                phase_items += pkt.size() - OPTS;
                since_cfg++;
                send_packet(-1);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("run covered %0d packets, %0d input beats and %0d register settings",
                 n_packets, sb.n_beats, n_settings);
        $display("checked %0d results: %0d data bytes, %0d complete, %0d not found,",
                 sb.n_results, sb.n_data, sb.status_seen[tlvox_pkg::ST_COMPLETE],
                 sb.status_seen[tlvox_pkg::ST_NOT_FOUND]);
        $display("  %0d malformed, %0d size mismatch",
                 sb.status_seen[tlvox_pkg::ST_MALFORMED],
                 sb.status_seen[tlvox_pkg::ST_SIZE_ERR]);
        if (sb.errors == 0 && sb.pending() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
